### hdl/sfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfw_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int THREAD_COUNT_DEF = 256;

  // semaphore count: 18-bit two's complement
  localparam int                 COUNT_W   = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  // configuration register width
  localparam int INIT_W = 16;

  // operation codes
  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_CLOSE  = 2'd2;
  localparam logic [1:0] OP_OPEN   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // commands broadcast to every queue cell
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/sfw_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sfw_cell #(
  parameter int TID_W = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  sfw_pkg::cell_ctl_t ctl,
  input  wire              prev_occ,
  input  wire              next_occ,
  input  wire  [TID_W-1:0] next_tid,
  input  wire  [TID_W-1:0] push_tid,
  output logic             occ,
  output logic [TID_W-1:0] tid
);
  import sfw_pkg::*;

  logic take_push;

  // the first free cell behind an occupied one takes a pushed id
  assign take_push = ctl.push && !occ && prev_occ;

  // occupancy, shifts toward the head on a pop
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      occ <= 1'b0;
    end else if (ctl.pop) begin
      occ <= next_occ;
    end else if (take_push) begin
      occ <= 1'b1;
    end
  end

  // thread id payload
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      tid <= next_tid;
    end else if (take_push) begin
      tid <= push_tid;
    end
  end

endmodule

`default_nettype wire

### hdl/counting_semaphore_fifo_wait.sv
`timescale 1ns / 1ps
`default_nettype none

// Counting semaphore with a FIFO of waiting thread ids, held in a row of
// QUEUE_DEPTH cells where cell 0 is the oldest waiter. Open, wait and signal
// produce one result each and can be accepted every cycle while the result
// register drains. Close on an open semaphore with N waiters enters a drain
// in which the cell row shifts out one waiter per cycle while the result
// register drains, one result per waiter, last on the final one; close with no
// waiters gives a single result. No new item is accepted during that drain.
// After reset the semaphore is closed and initial_count is 0; there is no
// clearing pass. initial_count may only be written while the block is idle.
module counting_semaphore_fifo_wait #(
  parameter int QUEUE_DEPTH  = sfw_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_COUNT = sfw_pkg::THREAD_COUNT_DEF,
  localparam int TID_W       = $clog2(THREAD_COUNT)
) (
  input  wire                     clk,
  input  wire                     rst,
  // configuration
  input  wire                     cfg_en,
  input  wire  [sfw_pkg::INIT_W-1:0] cfg_data,
  // request channel
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [1:0]              operation,
  input  wire  [TID_W-1:0]        thread_id,
  // result channel
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              status,
  output logic                    blocked,
  output logic                    woke_valid,
  output logic [TID_W-1:0]        woke_thread,
  output logic                    last
);
  import sfw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [INIT_W-1:0]  initial_count;
  logic [COUNT_W-1:0] count, count_next;
  logic               closed, closed_next;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] next_occ;
  logic [TID_W-1:0]       tid_q [QUEUE_DEPTH];
  cell_ctl_t              ctl;

  logic             out_free, in_fire, drain_fire, drain_last;
  logic             q_full, q_empty, cnt_le0, cnt_neg, cnt_sat;
  logic             load_out;
  logic [1:0]       res_status;
  logic             res_blocked, res_woke, res_last;
  logic [TID_W-1:0] res_thread;

  // handshake
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign drain_fire = (state == S_DRAIN) && out_free;
  assign drain_last = !next_occ[0];

  // queue and count conditions
  assign q_full  = occ[QUEUE_DEPTH-1];
  assign q_empty = !occ[0];
  assign cnt_neg = count[COUNT_W-1];
  assign cnt_le0 = cnt_neg || (count == '0);
  assign cnt_sat = (count == COUNT_MAX);

  // row of queue cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             prev_o;
    logic [TID_W-1:0] next_t;
    if (i == 0) begin : g_head
      assign prev_o = 1'b1;
    end else begin : g_body
      assign prev_o = occ[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_occ[i] = 1'b0;
      assign next_t      = '0;
    end else begin : g_inner
      assign next_occ[i] = occ[i+1];
      assign next_t      = tid_q[i+1];
    end
    sfw_cell #(
      .TID_W (TID_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev_occ (prev_o),
      .next_occ (next_occ[i]),
      .next_tid (next_t),
      .push_tid (thread_id),
      .occ      (occ[i]),
      .tid      (tid_q[i])
    );
  end

  // operation decode
  always_comb begin
    state_next  = state;
    count_next  = count;
    closed_next = closed;
    ctl         = '0;
    load_out    = 1'b0;
    res_status  = ST_OK;
    res_blocked = 1'b0;
    res_woke    = 1'b0;
    res_thread  = '0;
    res_last    = 1'b1;
    if (drain_fire) begin
      ctl.pop    = 1'b1;
      load_out   = 1'b1;
      res_woke   = 1'b1;
      res_thread = tid_q[0];
      res_last   = drain_last;
      if (drain_last) begin
        closed_next = 1'b1;
        state_next  = S_IDLE;
      end
    end else if (in_fire) begin
      load_out = 1'b1;
      if (operation == OP_OPEN) begin
        count_next  = {{(COUNT_W-INIT_W){1'b0}}, initial_count};
        ctl.clear   = 1'b1;
        closed_next = 1'b0;
      end else if (closed) begin
        res_status = ST_CLOSED;
      end else begin
        case (operation)
          OP_WAIT: begin
            if (cnt_le0 && q_full) begin
              res_status = ST_FULL;
            end else begin
              count_next  = count - COUNT_W'(1);
              ctl.push    = cnt_le0;
              res_blocked = cnt_le0;
            end
          end
          OP_SIGNAL: begin
            if (cnt_sat) begin
              res_status = ST_FULL;
            end else begin
              count_next = count + COUNT_W'(1);
              if (cnt_neg && !q_empty) begin
                ctl.pop    = 1'b1;
                res_woke   = 1'b1;
                res_thread = tid_q[0];
              end
            end
          end
          OP_CLOSE: begin
            if (q_empty) begin
              closed_next = 1'b1;
            end else begin
              load_out   = 1'b0;
              state_next = S_DRAIN;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      closed        <= 1'b1;
      initial_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      closed <= closed_next;
      if (cfg_en) begin
        initial_count <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      blocked     <= res_blocked;
      woke_valid  <= res_woke;
      woke_thread <= res_thread;
      last        <= res_last;
    end
  end

  // occupied cells always form a contiguous run from the head
  a_occ_contig: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + QUEUE_DEPTH'(1))) == '0)
    else $error("queue cells not contiguous");

  // draining only happens with a waiter at the head
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> occ[0])
    else $error("drain with empty queue");

  // the final waiter of a close leaves the semaphore closed and empty
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (drain_fire && drain_last) |=> (closed && !occ[0] && state == S_IDLE))
    else $error("close did not finish");

  // a blocked caller is never reported with a wakeup or an error
  a_blocked_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && blocked) |-> (status == ST_OK && !woke_valid && last))
    else $error("blocked result malformed");

endmodule

`default_nettype wire

### test/tb_counting_semaphore_fifo_wait.sv
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_wait;
  import sfw_pkg::*;

  localparam int TID_W        = 8;
  localparam int COUNT_TOP    = int'(COUNT_MAX);
  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam int RANDOM_CALLS = 140;

  typedef struct packed {
    logic [1:0]       status;
    logic             blocked;
    logic             woke_valid;
    logic [TID_W-1:0] woke_thread;
    logic             last;
  } sem_reply_t;

  // semaphore state mirror and queue of replies still owed by the block
  class semaphore_scoreboard;
    int               count;
    bit               closed;
    logic [TID_W-1:0] waiters[$];
    logic [INIT_W-1:0] initial_count;
    sem_reply_t       pending_replies[$];
    int               errors;

    function new();
      count = 0;
      closed = 1'b1;
      initial_count = '0;
      errors = 0;
    endfunction

    function void push_reply(logic [1:0] st, logic blk, logic wv, logic [TID_W-1:0] wt,
                             logic lst);
      sem_reply_t r;
      r.status = st;
      r.blocked = blk;
      r.woke_valid = wv;
      r.woke_thread = wt;
      r.last = lst;
      pending_replies.push_back(r);
    endfunction

    // work out the replies caused by one accepted call
    function void note_call(logic [1:0] op, logic [TID_W-1:0] tid);
      logic [TID_W-1:0] w;
      if (op == OP_OPEN) begin
        count = int'(initial_count);
        waiters.delete();
        closed = 1'b0;
        push_reply(ST_OK, 1'b0, 1'b0, '0, 1'b1);
      end else if (closed) begin
        push_reply(ST_CLOSED, 1'b0, 1'b0, '0, 1'b1);
      end else begin
        case (op)
          OP_WAIT: begin
            if (count - 1 < 0) begin
              if (waiters.size() >= QUEUE_DEPTH_DEF) begin
                push_reply(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
              end else begin
                count--;
                waiters.push_back(tid);
                push_reply(ST_OK, 1'b1, 1'b0, '0, 1'b1);
              end
            end else begin
              count--;
              push_reply(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
          end
          OP_SIGNAL: begin
            if (count >= COUNT_TOP) begin
              push_reply(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
            end else begin
              count++;
              if (count <= 0 && waiters.size() > 0) begin
                w = waiters.pop_front();
                push_reply(ST_OK, 1'b0, 1'b1, w, 1'b1);
              end else begin
                push_reply(ST_OK, 1'b0, 1'b0, '0, 1'b1);
              end
            end
          end
          OP_CLOSE: begin
            if (waiters.size() == 0) begin
              push_reply(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end else begin
              while (waiters.size() > 0) begin
                w = waiters.pop_front();
                push_reply(ST_OK, 1'b0, 1'b1, w, waiters.size() == 0);
              end
            end
            closed = 1'b1;
          end
          default: begin
          end
        endcase
      end
    endfunction

    // compare one reply transfer with the oldest owed reply
    function void check_reply(sem_reply_t got);
      sem_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing pending: status %0d woke %0d/%0d last %0d",
               got.status, got.woke_valid, got.woke_thread, got.last);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.blocked !== want.blocked) begin
        $error("blocked: expected %0d, actual %0d", want.blocked, got.blocked);
        errors++;
      end
      if (got.woke_valid !== want.woke_valid) begin
        $error("woke_valid: expected %0d, actual %0d", want.woke_valid, got.woke_valid);
        errors++;
      end
      if (got.woke_thread !== want.woke_thread) begin
        $error("woke_thread: expected %0d, actual %0d", want.woke_thread, got.woke_thread);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_en;
  logic [INIT_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        operation;
  logic [TID_W-1:0]  thread_id;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic              blocked;
  logic              woke_valid;
  logic [TID_W-1:0]  woke_thread;
  logic              last;

  semaphore_scoreboard sem_board = new();

  // idling controls shared by the driving processes, and a count of sent calls
  bit tx_idle;
  bit rx_idle;
  int rx_hold_off;
  int calls_sent;

  counting_semaphore_fifo_wait dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .thread_id  (thread_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .blocked    (blocked),
    .woke_valid (woke_valid),
    .woke_thread(woke_thread),
    .last       (last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one call and wait for its transfer
  task automatic send_call(input logic [1:0] op, input logic [TID_W-1:0] tid);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    thread_id <= tid;
    do @(posedge clk); while (!in_ready);
    sem_board.note_call(op, tid);
    calls_sent++;
  endtask

  // stop offering and let every owed reply drain
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sem_board.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_initial_count(input logic [INIT_W-1:0] value);
    drain_replies();
    cfg_en <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_en <= 1'b0;
    sem_board.initial_count = value;
  endtask

  // result side: random stall per reply, plus a one-off long hold-off
  initial begin : reply_sink
    int stall;
    sem_reply_t got;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (rx_hold_off > 0) begin
        stall = rx_hold_off;
        rx_hold_off = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status = status;
      got.blocked = blocked;
      got.woke_valid = woke_valid;
      got.woke_thread = woke_thread;
      got.last = last;
      sem_board.check_reply(got);
    end
  end

  initial begin : stimulus
    int k;
    int n;
    int style;
    int target;
    logic [1:0] op;
    logic [INIT_W-1:0] value;

    rst <= 1'b1;
    cfg_en <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= OP_WAIT;
    thread_id <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold_off = 0;
    calls_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // closed after reset, then the basic open / wait / signal / close paths
    send_call(OP_WAIT, 8'hFF);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_CLOSE, 8'h5A);
    send_call(OP_OPEN, 8'h00);
    send_call(OP_CLOSE, 8'h00);
    send_call(OP_OPEN, 8'hFF);
    send_call(OP_WAIT, 8'hFF);
    send_call(OP_WAIT, 8'h00);
    send_call(OP_SIGNAL, 8'hA5);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_WAIT, 8'h33);
    send_call(OP_WAIT, 8'hAA);
    // reopen drops the queued waiter without waking it
    send_call(OP_OPEN, 8'h00);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_CLOSE, 8'h00);

    // fill the wait queue, overflow it, then close with a full drain
    write_initial_count(16'd1);
    send_call(OP_OPEN, 8'h00);
    for (k = 0; k < QUEUE_DEPTH_DEF + 1; k++) begin
      send_call(OP_WAIT, TID_W'($urandom_range(0, 255)));
    end
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_WAIT, TID_W'($urandom_range(0, 255)));
    send_call(OP_WAIT, TID_W'($urandom_range(0, 255)));
    send_call(OP_WAIT, TID_W'($urandom_range(0, 255)));
    send_call(OP_CLOSE, 8'h00);

    // largest initial count, back to back on both sides
    write_initial_count(16'hFFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_call(OP_OPEN, 8'h00);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_WAIT, 8'h81);
    send_call(OP_SIGNAL, 8'h00);
    send_call(OP_SIGNAL, 8'h7E);
    send_call(OP_CLOSE, 8'h00);

    // back-pressure: sink holds off while calls keep coming
    write_initial_count(16'd0);
    send_call(OP_OPEN, 8'h00);
    rx_hold_off = 80;
    for (k = 0; k < 24; k++) begin
      send_call(k[0] ? OP_SIGNAL : OP_WAIT, TID_W'($urandom_range(0, 255)));
    end
    send_call(OP_CLOSE, 8'h00);

    // random sessions, mostly open / mixed calls / close
    target = calls_sent + RANDOM_CALLS;
    while (calls_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 5) == 0) value = 16'hFFFF;
        else if ($urandom_range(0, 4) == 0) value = INIT_W'($urandom_range(0, 65535));
        else value = INIT_W'($urandom_range(0, 6));
        write_initial_count(value);
      end
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) begin
          send_call(2'($urandom_range(0, 3)), TID_W'($urandom_range(0, 255)));
        end
      end else begin
        send_call(OP_OPEN, TID_W'($urandom_range(0, 255)));
        n = $urandom_range(4, 30);
        style = $urandom_range(0, 2);
        for (k = 0; k < n; k++) begin
          case (style)
            0: op = ($urandom_range(0, 3) == 0) ? OP_SIGNAL : OP_WAIT;
            1: op = $urandom_range(0, 1) ? OP_SIGNAL : OP_WAIT;
            default: op = ($urandom_range(0, 3) == 0) ? OP_WAIT : OP_SIGNAL;
          endcase
          if ($urandom_range(0, 24) == 0) op = OP_OPEN;
          send_call(op, TID_W'($urandom_range(0, 255)));
        end
        send_call(OP_CLOSE, TID_W'($urandom_range(0, 255)));
      end
    end

    // wrap up once every reply is in
    drain_replies();
    repeat (16) @(posedge clk);
    if (sem_board.errors == 0) begin
      $display("tb_counting_semaphore_fifo_wait: clean");
    end else begin
      $display("tb_counting_semaphore_fifo_wait: errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_counting_semaphore_fifo_wait: errors");
    $finish;
  end

endmodule

### filelist.f
hdl/sfw_pkg.sv
hdl/sfw_cell.sv
hdl/counting_semaphore_fifo_wait.sv
test/tb_counting_semaphore_fifo_wait.sv
